### hw/rtl/ppse_pkg.sv
// ----------------------------------------------------------------------------
// ppse_pkg
// Shared types, constants and codes of the pixel power-saving enhancer.
// ----------------------------------------------------------------------------
package ppse_pkg;

   localparam int LUMA_LEVELS_DEFAULT = 256;
   localparam int TABLE_WIDTH_DEFAULT = 16;

   localparam int CHAN_W  = 8;
   localparam int GAIN_W  = 16;
   localparam int DELTA_W = 21;

   // luma = (306*R + 601*G + 117*B + 512) >> 10
   localparam int LUMA_WR    = 306;
   localparam int LUMA_WG    = 601;
   localparam int LUMA_WB    = 117;
   localparam int LUMA_SHIFT = 10;
   localparam int LUMA_SUM_W = 18;

   // channel aligned to adj*delta (20 fraction bits), times gain -> 35
   localparam int CHAN_FRAC   = 20;
   localparam int ROUND_SHIFT = 35;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'h8000;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   typedef enum logic [1:0] {
      REG_GAIN        = 2'd0,
      REG_DELTA_RED   = 2'd1,
      REG_DELTA_GREEN = 2'd2,
      REG_DELTA_BLUE  = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic        command;
      logic [7:0]  table_index;
      logic [15:0] table_value;
      logic [7:0]  blue_in;
      logic [7:0]  green_in;
      logic [7:0]  red_in;
   } req_type;

   typedef struct packed {
      logic [7:0] blue_out;
      logic [7:0] green_out;
      logic [7:0] red_out;
   } rsp_type;

   // load enables of the channel datapath stages
   typedef struct packed {
      logic en3;
      logic en4;
      logic en5;
      logic en6;
   } stage_ctl_type;

endpackage

### hw/rtl/ppse_level_table.sv
// ----------------------------------------------------------------------------
// ppse_level_table
// Luma-indexed adjustment table, one write and one registered read port.
// ----------------------------------------------------------------------------
module ppse_level_table #(
   parameter int LUMA_LEVELS = ppse_pkg::LUMA_LEVELS_DEFAULT,
   parameter int TABLE_WIDTH = ppse_pkg::TABLE_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [$clog2(LUMA_LEVELS)-1:0] wr_addr,
   input  logic [TABLE_WIDTH-1:0]         wr_data,
   input  logic                           rd_en,
   input  logic [$clog2(LUMA_LEVELS)-1:0] rd_addr,
   output logic [TABLE_WIDTH-1:0]         rd_data
);
   import ppse_pkg::*;

   logic [TABLE_WIDTH-1:0] mem [LUMA_LEVELS];
   logic [TABLE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/ppse_channel_path.sv
// ----------------------------------------------------------------------------
// ppse_channel_path
// One color channel: adj*delta, subtract, times gain, round and clamp.
// ----------------------------------------------------------------------------
module ppse_channel_path #(
   parameter int TABLE_WIDTH = ppse_pkg::TABLE_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  ppse_pkg::stage_ctl_type       ctl,
   input  logic [TABLE_WIDTH-1:0]        adj,
   input  logic [ppse_pkg::CHAN_W-1:0]   chan,
   input  logic signed [ppse_pkg::DELTA_W-1:0] delta,
   input  logic [ppse_pkg::GAIN_W-1:0]   gain,
   output logic [ppse_pkg::CHAN_W-1:0]   chan_out
);
   import ppse_pkg::*;

   localparam int PW = TABLE_WIDTH + DELTA_W + 1;   // signed product
   localparam int DW = PW + 1;                      // signed difference
   localparam int MW = DW - 1 + GAIN_W;             // positive part times gain
   localparam int HW = MW + 1 - ROUND_SHIFT;        // rounded integer part

   // stage 3: product
   logic signed [PW-1:0] adj_ext;
   logic signed [PW-1:0] delta_ext;
   logic signed [PW-1:0] prod3_in, prod3_ff;
   logic [CHAN_W-1:0]    chan3_ff;

   assign adj_ext   = PW'($signed({1'b0, adj}));
   assign delta_ext = PW'(delta);
   assign prod3_in  = adj_ext * delta_ext;

   always_ff @(posedge clock) begin
      if (ctl.en3) begin
         prod3_ff <= prod3_in;
         chan3_ff <= chan;
      end
   end

   // stage 4: difference
   logic signed [DW-1:0] chan_ext;
   logic signed [DW-1:0] diff4_in, diff4_ff;

   assign chan_ext = DW'($signed({1'b0, chan3_ff, {CHAN_FRAC{1'b0}}}));
   assign diff4_in = chan_ext - DW'(prod3_ff);

   always_ff @(posedge clock) begin
      if (ctl.en4) begin
         diff4_ff <= diff4_in;
      end
   end

   // stage 5: scale; a non-positive difference flushes to zero later
   logic          pos5_in, pos5_ff;
   logic [MW-1:0] mag5_in, mag5_ff;

   assign pos5_in = !diff4_ff[DW-1] && (diff4_ff != '0);
   assign mag5_in = MW'(diff4_ff[DW-2:0]) * MW'(gain);

   always_ff @(posedge clock) begin
      if (ctl.en5) begin
         pos5_ff <= pos5_in;
         mag5_ff <= mag5_in;
      end
   end

   // stage 6: round half up, saturate, output register
   localparam logic [MW:0] ROUND_HALF = (MW + 1)'(1) << (ROUND_SHIFT - 1);

   logic [MW:0]       round_sum;
   logic [HW-1:0]     round_int;
   logic              sat;
   logic [CHAN_W-1:0] chan6_in, chan6_ff;

   assign round_sum = (MW + 1)'(mag5_ff) + ROUND_HALF;
   assign round_int = round_sum[MW:ROUND_SHIFT];
   assign sat       = |round_int[HW-1:CHAN_W];

   always_comb begin
      priority if (!pos5_ff) begin
         chan6_in = '0;
      end else if (sat) begin
         chan6_in = '1;
      end else begin
         chan6_in = round_int[CHAN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en6) begin
         chan6_ff <= chan6_in;
      end
   end

   assign chan_out = chan6_ff;

endmodule

### hw/rtl/pixel_power_saving_enhancer_unit.sv
// ----------------------------------------------------------------------------
// pixel_power_saving_enhancer_unit
// Throughput: one beat per cycle while rsp_stall is low; six register stages,
// the table read sits in stage 2 and the two multipliers per channel in
// stages 3 and 5.
// Reset (synchronous): pipeline empties, gain = 1.0, deltas = 0; table kept.
// ----------------------------------------------------------------------------
module pixel_power_saving_enhancer_unit #(
   parameter int LUMA_LEVELS = ppse_pkg::LUMA_LEVELS_DEFAULT,
   parameter int TABLE_WIDTH = ppse_pkg::TABLE_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // input beats
   input  logic              req_valid,
   output logic              req_stall,
   input  ppse_pkg::req_type req_data,
   // result beats
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ppse_pkg::rsp_type rsp_data,
   // register port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import ppse_pkg::*;

   localparam int LW = $clog2(LUMA_LEVELS);

   // ------------------------------------------------------------------
   // Registers. To be written only while the pipeline is idle (the block
   // itself does not enforce this), so the datapath reads them directly.
   // ------------------------------------------------------------------
   logic [GAIN_W-1:0]         gain_ff;
   logic signed [DELTA_W-1:0] delta_red_ff, delta_green_ff, delta_blue_ff;
   reg_index_type             csr_index;
   logic                      csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[3:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff        <= GAIN_RESET;
         delta_red_ff   <= '0;
         delta_green_ff <= '0;
         delta_blue_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_GAIN:        gain_ff        <= csr_pwdata[GAIN_W-1:0];
            REG_DELTA_RED:   delta_red_ff   <= csr_pwdata[DELTA_W-1:0];
            REG_DELTA_GREEN: delta_green_ff <= csr_pwdata[DELTA_W-1:0];
            REG_DELTA_BLUE:  delta_blue_ff  <= csr_pwdata[DELTA_W-1:0];
            default: ;
         endcase
      end
   end

   // reads return the value; deltas sign-extended
   always_comb begin
      unique case (csr_index)
         REG_GAIN:        csr_prdata = 32'(gain_ff);
         REG_DELTA_RED:   csr_prdata = 32'(delta_red_ff);
         REG_DELTA_GREEN: csr_prdata = 32'(delta_green_ff);
         REG_DELTA_BLUE:  csr_prdata = 32'(delta_blue_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Pipeline control. A stage loads when it is empty or its contents move
   // on, so bubbles close up and the input keeps flowing while a finished
   // result waits at the output, until every stage holds an item.
   // ------------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   logic en1, en2, en3, en4, en5, en6;
   stage_ctl_type ctl;

   assign en6 = !v6_ff || !rsp_stall;
   assign en5 = !v5_ff || en6;
   assign en4 = !v4_ff || en5;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;

   assign req_stall = !en1;
   assign ctl       = '{en3: en3, en4: en4, en5: en5, en6: en6};

   // ------------------------------------------------------------------
   // Stage 1: capture beat, compute luma and clamp it to the table.
   // ------------------------------------------------------------------
   logic [LUMA_SUM_W-1:0] luma_sum;
   logic [7:0]            luma_raw;
   logic [LW-1:0]         luma_idx;

   assign luma_sum = LUMA_SUM_W'(LUMA_WR) * LUMA_SUM_W'(req_data.red_in)
                   + LUMA_SUM_W'(LUMA_WG) * LUMA_SUM_W'(req_data.green_in)
                   + LUMA_SUM_W'(LUMA_WB) * LUMA_SUM_W'(req_data.blue_in)
                   + (LUMA_SUM_W'(1) << (LUMA_SHIFT - 1));
   assign luma_raw = luma_sum[LUMA_SUM_W-1:LUMA_SHIFT];

   always_comb begin
      if (int'(luma_raw) >= LUMA_LEVELS) begin
         luma_idx = LW'(LUMA_LEVELS - 1);
      end else begin
         luma_idx = LW'(luma_raw);
      end
   end

   logic                   cmd1_ff;
   logic                   idx_ok1_ff;
   logic [LW-1:0]          idx1_ff;
   logic [TABLE_WIDTH-1:0] val1_ff;
   logic [LW-1:0]          luma1_ff;
   logic [CHAN_W-1:0]      blue1_ff, green1_ff, red1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en1) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         cmd1_ff    <= req_data.command;
         idx_ok1_ff <= int'(req_data.table_index) < LUMA_LEVELS;
         idx1_ff    <= LW'(req_data.table_index);
         val1_ff    <= TABLE_WIDTH'(req_data.table_value);
         luma1_ff   <= luma_idx;
         blue1_ff   <= req_data.blue_in;
         green1_ff  <= req_data.green_in;
         red1_ff    <= req_data.red_in;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: table access. Loads write as they leave stage 1 and end
   // there; a pixel behind a load reads after the write and sees it.
   // ------------------------------------------------------------------
   logic                   tbl_wr_en;
   logic [TABLE_WIDTH-1:0] adj2;
   logic [CHAN_W-1:0]      blue2_ff, green2_ff, red2_ff;

   assign tbl_wr_en = en2 && v1_ff && (cmd1_ff == CMD_LOAD) && idx_ok1_ff;

   ppse_level_table #(
      .LUMA_LEVELS (LUMA_LEVELS),
      .TABLE_WIDTH (TABLE_WIDTH)
   ) u_level_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (idx1_ff),
      .wr_data (val1_ff),
      .rd_en   (en2),
      .rd_addr (luma1_ff),
      .rd_data (adj2)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en2) begin
         v2_ff <= v1_ff && (cmd1_ff == CMD_PIXEL);
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         blue2_ff  <= blue1_ff;
         green2_ff <= green1_ff;
         red2_ff   <= red1_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stages 3..6: per-channel arithmetic, valid bits kept here.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
         if (en5) v5_ff <= v4_ff;
         if (en6) v6_ff <= v5_ff;
      end
   end

   ppse_channel_path #(.TABLE_WIDTH(TABLE_WIDTH)) u_blue (
      .clock    (clock),
      .ctl      (ctl),
      .adj      (adj2),
      .chan     (blue2_ff),
      .delta    (delta_blue_ff),
      .gain     (gain_ff),
      .chan_out (rsp_data.blue_out)
   );

   ppse_channel_path #(.TABLE_WIDTH(TABLE_WIDTH)) u_green (
      .clock    (clock),
      .ctl      (ctl),
      .adj      (adj2),
      .chan     (green2_ff),
      .delta    (delta_green_ff),
      .gain     (gain_ff),
      .chan_out (rsp_data.green_out)
   );

   ppse_channel_path #(.TABLE_WIDTH(TABLE_WIDTH)) u_red (
      .clock    (clock),
      .ctl      (ctl),
      .adj      (adj2),
      .chan     (red2_ff),
      .delta    (delta_red_ff),
      .gain     (gain_ff),
      .chan_out (rsp_data.red_out)
   );

   assign rsp_valid = v6_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
`ifndef SYNTHESIS
   // an accepted beat lands in stage 1
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted beat not captured in stage 1");

   // input only stalls behind an occupied stage 1
   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> v1_ff)
      else $error("input stalled with empty stage 1");

   // a table load never moves on into the arithmetic stages
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      tbl_wr_en |=> !v2_ff)
      else $error("table load produced a stage 2 item");
`endif

endmodule

### dv/pixel_power_saving_enhancer_unit_tb.sv
// ----------------------------------------------------------------------------
// pixel_power_saving_enhancer_unit_tb
// Self-checking bench for the pixel power-saving enhancer. Loads the luma
// table over the input channel, programs gain and channel deltas over the
// register port, and streams BGR pixels with random gaps and output stalls.
// A scoreboard predicts every adjusted pixel and checks the result beats in
// order.
// ----------------------------------------------------------------------------
module pixel_power_saving_enhancer_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ppse_pkg::*;

   localparam int CLOCK_HALF      = 4;
   localparam int RESET_CYCLES    = 7;
   localparam int PIPE_LATENCY    = 6;
   // loads give no result and may still sit in the pipe when the last pixel
   // has come out, so wait a bit beyond the latency before touching registers
   localparam int SETTLE_CYCLES   = PIPE_LATENCY + 6;
   localparam int HOLD_OFF_CYCLES = 250;
   localparam int PHASE_ITEMS     = 150;
   localparam int CYCLE_LIMIT     = 1_000_000;

   // -------------------------------------------------------------------------
   // Scoreboard: own copy of the table and registers, queue of expected
   // pixels in acceptance order.
   // -------------------------------------------------------------------------
   class pixel_scoreboard;
      logic [15:0]        level_table [256];
      bit                 loaded [256];
      logic [15:0]        gain_q15;
      logic signed [20:0] delta_red;
      logic signed [20:0] delta_green;
      logic signed [20:0] delta_blue;
      rsp_type            expected_pixels [$];
      int unsigned        pixels;
      int unsigned        loads;
      int unsigned        matched;
      int unsigned        errors;

      function new();
         gain_q15    = GAIN_RESET;
         delta_red   = '0;
         delta_green = '0;
         delta_blue  = '0;
         foreach (loaded[i]) loaded[i] = 1'b0;
         pixels  = 0;
         loads   = 0;
         matched = 0;
         errors  = 0;
      endfunction

      static function int unsigned luma_level(logic [7:0] b, logic [7:0] g, logic [7:0] r);
         return (LUMA_WR * r + LUMA_WG * g + LUMA_WB * b + (1 << (LUMA_SHIFT - 1)))
                >> LUMA_SHIFT;
      endfunction

      function void apply_register(reg_index_type idx, logic [31:0] value);
         case (idx)
            REG_GAIN:        gain_q15    = value[GAIN_W-1:0];
            REG_DELTA_RED:   delta_red   = value[DELTA_W-1:0];
            REG_DELTA_GREEN: delta_green = value[DELTA_W-1:0];
            REG_DELTA_BLUE:  delta_blue  = value[DELTA_W-1:0];
            default: ;
         endcase
      endfunction

      // gain * (chan - adj*delta), 35 fraction bits, round half up, clamp 0..255
      function logic [7:0] scaled_channel(logic [7:0] chan, logic [15:0] adj,
                                          logic signed [20:0] delta);
         longint diff;
         longint prod;
         diff = (longint'(chan) <<< CHAN_FRAC) - longint'(adj) * longint'(delta);
         prod = diff * longint'(gain_q15);
         if (prod <= 0) return 8'd0;
         prod = (prod + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
         return (prod > 255) ? 8'd255 : prod[7:0];
      endfunction

      function void note_request(req_type item);
         rsp_type     px;
         logic [15:0] adj;
         if (item.command == CMD_LOAD) begin
            level_table[item.table_index] = item.table_value;
            loaded[item.table_index]      = 1'b1;
            loads++;
         end else begin
            adj = level_table[luma_level(item.blue_in, item.green_in, item.red_in)];
            px.blue_out  = scaled_channel(item.blue_in,  adj, delta_blue);
            px.green_out = scaled_channel(item.green_in, adj, delta_green);
            px.red_out   = scaled_channel(item.red_in,   adj, delta_red);
            expected_pixels.push_back(px);
            pixels++;
         end
      endfunction

      function bit field_ok(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
            return 1'b0;
         end
         return 1'b1;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         bit      ok;
         if (expected_pixels.size() == 0) begin
            $display("%0t: result beat with nothing expected, expected none, got %h",
                     $time, got);
            errors++;
            return;
         end
         want = expected_pixels.pop_front();
         ok   = field_ok("blue_out", want.blue_out, got.blue_out);
         ok   = field_ok("green_out", want.green_out, got.green_out) && ok;
         ok   = field_ok("red_out", want.red_out, got.red_out) && ok;
         if (ok) matched++;
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals
   // -------------------------------------------------------------------------
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   req_type     req_data    = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   rsp_type     rsp_data;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pixel_scoreboard sb = new();

   bit          quiet_phase      = 1'b0;  // no gaps, no stalls
   bit          hold_off_pending = 1'b0;  // asks the receiver for a long hold
   int unsigned hold_offs        = 0;
   int unsigned settings         = 1;     // reset values count as the first
   int unsigned cycle_count      = 0;

   pixel_power_saving_enhancer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #CLOCK_HALF;
      clock = 1'b1;
      #CLOCK_HALF;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d pixels still expected",
                  CYCLE_LIMIT, sb.expected_pixels.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Result monitor. Sampled in the active region of the rising edge, so the
   // DUT's registered outputs still show their pre-edge values.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) sb.check_result(rsp_data);
   end

   // -------------------------------------------------------------------------
   // Random shaping helpers
   // -------------------------------------------------------------------------
   // mostly short idles, now and then a long one
   function automatic int unsigned idle_len();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int unsigned next_gap();
      return quiet_phase ? 0 : idle_len();
   endfunction

   // table values: zero, full scale, near 1.0 (usable range), anything
   function automatic logic [15:0] pick_table_value();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return 16'h0000;
      if (pick < 20) return 16'hFFFF;
      if (pick < 70) return 16'($urandom_range(0, 16'h2000));
      return 16'($urandom);
   endfunction

   function automatic logic [7:0] pick_channel();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) return 8'd0;
      if (pick < 24) return 8'd255;
      return 8'($urandom);
   endfunction

   // -------------------------------------------------------------------------
   // Output side: random stall runs, quiet stretches, and on request one long
   // hold-off counted here so the pipe backs up into req_stall.
   // -------------------------------------------------------------------------
   initial begin : receiver
      int unsigned run;
      bit          level;
      forever begin
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            hold_offs++;
            level = 1'b1;
            run   = HOLD_OFF_CYCLES;
         end else if (quiet_phase) begin
            level = 1'b0;
            run   = 1;
         end else begin
            level = ($urandom_range(0, 3) == 0);
            run   = level ? idle_len() + 1 : $urandom_range(1, 12);
         end
         repeat (run) begin
            @(negedge clock);
            rsp_stall <= level;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Input side
   // -------------------------------------------------------------------------
   // Drives one beat after an optional gap. Valid stays high after acceptance
   // until the next negedge decides what comes next, so it is never dropped
   // and raised in the same step.
   task automatic send_beat(input req_type item, input int unsigned gap);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      sb.note_request(item);
   endtask

   task automatic send_load(input logic [7:0] idx, input logic [15:0] value,
                            input int unsigned gap);
      req_type item;
      item.command     = CMD_LOAD;
      item.table_index = idx;
      item.table_value = value;
      // pixel fields are don't-care on a load; keep them moving
      item.blue_in     = 8'($urandom);
      item.green_in    = 8'($urandom);
      item.red_in      = 8'($urandom);
      send_beat(item, gap);
   endtask

   // Never lets a pixel read an entry that was never loaded: the entry is
   // loaded first with a random value.
   task automatic send_pixel(input logic [7:0] b, input logic [7:0] g,
                             input logic [7:0] r);
      req_type     item;
      int unsigned luma;
      luma = pixel_scoreboard::luma_level(b, g, r);
      if (!sb.loaded[luma]) send_load(8'(luma), pick_table_value(), next_gap());
      item.command     = CMD_PIXEL;
      item.table_index = 8'($urandom);
      item.table_value = 16'($urandom);
      item.blue_in     = b;
      item.green_in    = g;
      item.red_in      = r;
      send_beat(item, next_gap());
   endtask

   task automatic send_random_item();
      if ($urandom_range(0, 99) < 15)
         send_load(8'($urandom), pick_table_value(), next_gap());
      else
         send_pixel(pick_channel(), pick_channel(), pick_channel());
   endtask

   // Sender pause: drop valid, let every expected pixel come out, then allow
   // trailing loads to clear the pipe.
   task automatic drain_and_settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Register port: setup cycle, access cycle, write lands when pready is up.
   // -------------------------------------------------------------------------
   task automatic write_register(input reg_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.apply_register(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic program_settings(input logic [15:0] gain, input int dr,
                                   input int dg, input int db);
      drain_and_settle();
      write_register(REG_GAIN, {16'd0, gain});
      write_register(REG_DELTA_RED, 32'(dr));
      write_register(REG_DELTA_GREEN, 32'(dg));
      write_register(REG_DELTA_BLUE, 32'(db));
      settings++;
   endtask

   // -------------------------------------------------------------------------
   // Directed: table extremes, black/white/primaries/mid gray, first under the
   // reset registers, then under max gain with opposing extreme deltas (one
   // channel driven below zero, one saturated).
   // -------------------------------------------------------------------------
   task automatic directed_checks();
      send_load(8'd0,   16'h0000, 0);
      send_load(8'd255, 16'hFFFF, 0);
      send_load(8'd128, 16'h1000, 0);
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd128, 8'd128, 8'd128);
      program_settings(16'hFFFF, 1048575, -1048576, 256);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd1,   8'd1,   8'd1);
      send_pixel(8'd0,   8'd255, 8'd0);
   endtask

   task automatic run_phase(input logic [15:0] gain, input int dr, input int dg,
                            input int db, input bit hold_off, input bit quiet,
                            input bit pause);
      program_settings(gain, dr, dg, db);
      quiet_phase = quiet;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         // long output hold while the sender keeps offering beats
         if (hold_off && i == PHASE_ITEMS / 3) hold_off_pending = 1'b1;
         if (pause && i == PHASE_ITEMS / 2) drain_and_settle();
         send_random_item();
      end
      quiet_phase = 1'b0;
   endtask

   function automatic int full_delta();
      return int'($urandom_range(0, 2097151)) - 1048576;
   endfunction

   // deltas around +-128.0 keep most outputs off the clamps
   function automatic int usable_delta();
      return int'($urandom_range(0, 65536)) - 32768;
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_checks();

      // fill the whole table so random pixels can use any luma
      for (int i = 0; i < 256; i++) send_load(8'(i), pick_table_value(), next_gap());

      run_phase(16'h0000, full_delta(), full_delta(), full_delta(), 0, 0, 0);
      run_phase(16'hFFFF, 1048575, 1048575, 1048575, 0, 0, 0);
      run_phase(16'hFFFF, -1048576, -1048576, -1048576, 0, 0, 0);
      run_phase(GAIN_RESET, 0, 0, 0, 0, 0, 0);
      run_phase(16'($urandom_range(16'h4000, 16'hFFFF)), usable_delta(),
                usable_delta(), usable_delta(), 0, 0, 1);
      run_phase(16'($urandom_range(16'h4000, 16'hFFFF)), usable_delta(),
                usable_delta(), usable_delta(), 1, 0, 0);
      run_phase(16'($urandom_range(16'h4000, 16'hFFFF)), usable_delta(),
                usable_delta(), usable_delta(), 0, 1, 0);
      run_phase(16'($urandom), usable_delta(), usable_delta(), usable_delta(), 0, 0, 0);
      run_phase(16'($urandom), full_delta(), usable_delta(), full_delta(), 0, 0, 0);

      drain_and_settle();

      $display("Covered %0d pixel beats and %0d table loads over %0d register settings,",
               sb.pixels, sb.loads, settings);
      $display("with random gaps/stalls, a quiet stretch and %0d long output hold-off(s).",
               hold_offs);
      if (sb.errors == 0 && sb.expected_pixels.size() == 0 && sb.matched == sb.pixels) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d pixels never returned",
                  sb.errors, sb.expected_pixels.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
